@@ rtl/core/sle_pkg.sv @@
package sle_pkg;

  // default table depth
  localparam int unsigned CapacityDef = 16;

  // field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = $clog2(CapacityDef + 1);

  // command codes
  localparam logic [ModeW-1:0] MODE_INSERT = 3'd0;
  localparam logic [ModeW-1:0] MODE_SEARCH = 3'd1;
  localparam logic [ModeW-1:0] MODE_DELETE = 3'd2;
  localparam logic [ModeW-1:0] MODE_DRAIN  = 3'd3;
  localparam logic [ModeW-1:0] MODE_LIST   = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] ST_DONE      = 3'd0;
  localparam logic [StatusW-1:0] ST_FOUND     = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        entry_count;
    logic                     last;
  } res_t;

endpackage

@@ rtl/core/sle_ram.sv @@
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sorted_list_engine.sv @@
// Sorted table of signed 32-bit values held in one single-port-read RAM. A command is
// taken when start is high and busy is low; results come out one per result_valid_o
// pulse and cannot be held off, so the receiver must take each one in the cycle it is
// shown. Each entry that a table walk touches is read from the RAM, then compared and
// written back: insert walks down from the top over every entry not smaller than the
// value and writes the value above the smaller entry where the walk stops, or places
// it in the bottom slot when no entry is smaller; search and delete scan the entries
// in order (delete always scans to the end of the table), drain and list emit one
// result per entry read. Full, empty and unknown-command cases answer at once, in the
// cycle after the command is taken.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic result_valid_o,
  output res_t result_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            found_q, found_d;
  cmd_t            cmd_q, cmd_d;
  res_t            res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [ValueW-1:0] ram_rdata;

  logic signed [ValueW-1:0] rd_val;
  logic [CntW-1:0]  last_idx;
  logic             at_end;
  logic             hit;
  logic             new_found;
  logic             accept;

  sle_ram #(
    .Width(ValueW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_val    = $signed(ram_rdata);
  assign last_idx  = count_q - CntW'(1);
  assign at_end    = (CntW'(idx_q) == last_idx);
  assign hit       = (rd_val == cmd_q.value);
  assign new_found = found_q | hit;
  assign accept    = start && (state_q == S_IDLE);

  // sequencer and table update
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = cmd_q.value;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d                = cmd_i;
          found_d              = 1'b0;
          idx_d                = '0;
          res_d.entry_value    = cmd_i.value;
          res_d.entry_count    = CountW'(count_q);
          res_d.last           = 1'b1;
          case (cmd_i.mode)
            MODE_INSERT: begin
              if (count_q >= CntW'(Capacity)) begin
                res_d.status = ST_FULL;
                res_valid_d  = 1'b1;
              end else if (count_q == '0) begin
                ram_we            = 1'b1;
                ram_waddr         = '0;
                ram_wdata         = cmd_i.value;
                count_d           = CntW'(1);
                res_d.status      = ST_DONE;
                res_d.entry_count = CountW'(1);
                res_valid_d       = 1'b1;
              end else begin
                idx_d   = AddrW'(last_idx);
                state_d = S_RD;
              end
            end
            MODE_SEARCH: begin
              if (count_q == '0) begin
                res_d.status = ST_NOT_FOUND;
                res_valid_d  = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            MODE_DELETE, MODE_DRAIN, MODE_LIST: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                res_valid_d  = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              res_d.status = ST_NOT_FOUND;
              res_valid_d  = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CHK;
      end

      S_CHK: begin
        res_d.entry_value = cmd_q.value;
        res_d.entry_count = CountW'(count_q);
        res_d.last        = 1'b1;
        case (cmd_q.mode)
          // walk down from the top, moving entries not smaller up by one
          MODE_INSERT: begin
            ram_we = 1'b1;
            ram_waddr = idx_q + AddrW'(1);
            if (rd_val >= cmd_q.value) begin
              ram_wdata = ram_rdata;
              if (idx_q == '0) begin
                state_d = S_PUT;
              end else begin
                idx_d   = idx_q - AddrW'(1);
                state_d = S_RD;
              end
            end else begin
              ram_wdata         = cmd_q.value;
              count_d           = count_q + CntW'(1);
              res_d.status      = ST_DONE;
              res_d.entry_count = CountW'(count_q + CntW'(1));
              res_valid_d       = 1'b1;
              state_d           = S_IDLE;
            end
          end
          MODE_SEARCH: begin
            if (hit || at_end) begin
              res_d.status = hit ? ST_FOUND : ST_NOT_FOUND;
              res_valid_d  = 1'b1;
              state_d      = S_IDLE;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = S_RD;
            end
          end
          // after the first match every later entry moves down by one
          MODE_DELETE: begin
            if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = idx_q - AddrW'(1);
              ram_wdata = ram_rdata;
            end
            found_d = new_found;
            if (at_end) begin
              if (new_found) begin
                count_d           = last_idx;
                res_d.status      = ST_DONE;
                res_d.entry_count = CountW'(last_idx);
              end else begin
                res_d.status = ST_NOT_FOUND;
              end
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = S_RD;
            end
          end
          MODE_DRAIN, MODE_LIST: begin
            res_d.status      = ST_DONE;
            res_d.entry_value = rd_val;
            res_d.entry_count = (cmd_q.mode == MODE_DRAIN) ? '0 : CountW'(count_q);
            res_d.last        = at_end;
            res_valid_d       = 1'b1;
            if (at_end) begin
              if (cmd_q.mode == MODE_DRAIN) begin
                count_d = '0;
              end
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // value goes to the bottom slot after the whole table moved up
      S_PUT: begin
        ram_we            = 1'b1;
        ram_waddr         = '0;
        ram_wdata         = cmd_q.value;
        count_d           = count_q + CntW'(1);
        res_d.status      = ST_DONE;
        res_d.entry_value = cmd_q.value;
        res_d.entry_count = CountW'(count_q + CntW'(1));
        res_d.last        = 1'b1;
        res_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    found_q <= found_d;
    cmd_q   <= cmd_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
